[design/prdt_pkg.sv]
// Package for the port receive dispatch table.
// Holds the operation and status codes and the request and result structs.
// No dependencies.
package prdt_pkg;

    localparam int SLOT_W = 3;

    typedef enum logic [1:0] {
        OP_REGISTER     = 2'd0,
        OP_DEREGISTER   = 2'd1,
        OP_RECEIVE      = 2'd2,
        OP_DELETE_RANGE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOMATCH = 2'd2
    } t_status;

    typedef struct packed {
        t_op         op;
        logic [15:0] port;
        logic [7:0]  length_limit;
        logic [15:0] ready_address;
        logic [15:0] buffer_address;
        logic [15:0] info_address;
        logic [7:0]  task_id;
        logic [7:0]  packet_length;
        logic [7:0]  signal_strength;
        logic [7:0]  link_quality;
        logic [15:0] range_start;
        logic [15:0] range_end;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        copy_length;
        logic [15:0]       out_buffer_address;
        logic [15:0]       out_ready_address;
        logic [15:0]       out_info_address;
        logic              write_info;
        logic [7:0]        out_strength;
        logic [7:0]        out_quality;
        logic              post_task;
        logic [7:0]        out_task_id;
    } t_rsp;

    typedef struct packed {
        logic [15:0] port;
        logic [7:0]  limit;
        logic [15:0] ready_address;
        logic [15:0] buffer_address;
        logic [15:0] info_address;
        logic [7:0]  task_id;
    } t_entry;

    typedef struct packed {
        logic free;
        logic port;
        logic range;
    } t_found;

endpackage

[design/prdt_match.sv]
// Parallel search of the dispatch table for one request.
// Finds the lowest free slot, the lowest valid slot on a port and the slots in a
// ready-address range. Depends on prdt_pkg.
module prdt_match #(
    parameter int SLOTS = 8,
    parameter int IDX_W = 3
) (
    input  logic [SLOTS-1:0]      i_valid,
    input  prdt_pkg::t_entry      i_entry [SLOTS],
    input  logic [15:0]           i_port,
    input  logic [15:0]           i_range_start,
    input  logic [15:0]           i_range_end,
    output prdt_pkg::t_found      o_found,
    output logic [IDX_W-1:0]      o_free_idx,
    output logic [IDX_W-1:0]      o_port_idx,
    output logic [IDX_W-1:0]      o_range_idx,
    output logic [SLOTS-1:0]      o_range_hits
);
    import prdt_pkg::*;

    logic [SLOTS-1:0] w_port_hits;

    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            w_port_hits[s]  = i_valid[s] && (i_entry[s].port == i_port);
            o_range_hits[s] = i_valid[s] && (i_entry[s].ready_address >= i_range_start)
                              && (i_entry[s].ready_address <= i_range_end);
        end
    end

    always_comb begin
        o_found     = '0;
        o_free_idx  = '0;
        o_port_idx  = '0;
        o_range_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!i_valid[s]) begin
                o_found.free = 1'b1;
                o_free_idx   = IDX_W'(s);
            end
            if (w_port_hits[s]) begin
                o_found.port = 1'b1;
                o_port_idx   = IDX_W'(s);
            end
            if (o_range_hits[s]) begin
                o_found.range = 1'b1;
                o_range_idx   = IDX_W'(s);
            end
        end
    end

endmodule

[design/port_receive_dispatch_table.sv]
// Top level of the port receive dispatch table.
// Holds the table, the request register and the result register.
// Depends on prdt_pkg and prdt_match.
//
// Usage: a request arrives on i_in (valid/ready) carrying an operation:
// register, deregister, receive or delete by ready-address range. Each request
// produces exactly one result on o_out (valid/ready), in request order.
// A request accepted on i_in is captured in the request register; when it
// advances, the table is searched and updated and the result is registered in
// the output register, which drives o_out_valid. The table is flip-flops
// searched in parallel, so a request can be accepted every cycle and the
// sustained rate is one request per cycle while the receiver keeps up.
// When the receiver stalls, the result waits in the output register and one
// further request is held in the request register; o_in_ready then falls.
// Reset clears the valid bits of the table and of both pipeline registers; the
// table is usable in the first cycle after reset.
module port_receive_dispatch_table #(
    parameter int SLOTS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  prdt_pkg::t_req   i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output prdt_pkg::t_rsp   o_out
);
    import prdt_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic             r_in_valid;
    t_req             r_in;
    logic             r_out_valid;
    t_rsp             r_out;
    logic [SLOTS-1:0] r_valid;
    logic [SLOTS-1:0] n_valid;
    t_entry           r_entry [SLOTS];

    logic             w_advance;
    t_found           w_found;
    logic [IDX_W-1:0] w_free_idx;
    logic [IDX_W-1:0] w_port_idx;
    logic [IDX_W-1:0] w_range_idx;
    logic [SLOTS-1:0] w_range_hits;
    t_entry           w_hit;
    t_rsp             n_out;

    function automatic logic [SLOT_W-1:0] f_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] ext;
        ext = {{SLOT_W{1'b0}}, idx};
        return ext[SLOT_W-1:0];
    endfunction

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    prdt_match #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_match (
        .i_valid       (r_valid),
        .i_entry       (r_entry),
        .i_port        (r_in.port),
        .i_range_start (r_in.range_start),
        .i_range_end   (r_in.range_end),
        .o_found       (w_found),
        .o_free_idx    (w_free_idx),
        .o_port_idx    (w_port_idx),
        .o_range_idx   (w_range_idx),
        .o_range_hits  (w_range_hits)
    );

    assign w_hit = r_entry[w_port_idx];

    always_comb begin
        n_out        = '0;
        n_out.status = ST_NOMATCH;
        n_valid      = r_valid;
        unique case (r_in.op)
            OP_REGISTER: begin
                if (w_found.free) begin
                    n_out.status        = ST_DONE;
                    n_out.slot          = f_slot(w_free_idx);
                    n_valid[w_free_idx] = 1'b1;
                end else begin
                    n_out.status = ST_FULL;
                end
            end
            OP_DEREGISTER: begin
                if (w_found.port) begin
                    n_out.status        = ST_DONE;
                    n_out.slot          = f_slot(w_port_idx);
                    n_valid[w_port_idx] = 1'b0;
                end
            end
            OP_RECEIVE: begin
                if (w_found.port) begin
                    n_out.status             = ST_DONE;
                    n_out.slot               = f_slot(w_port_idx);
                    n_out.copy_length        = (r_in.packet_length > w_hit.limit) ?
                                               w_hit.limit : r_in.packet_length;
                    n_out.out_buffer_address = w_hit.buffer_address;
                    n_out.out_ready_address  = w_hit.ready_address;
                    n_out.out_info_address   = w_hit.info_address;
                    n_out.write_info         = (w_hit.info_address != '0);
                    n_out.out_strength       = n_out.write_info ? r_in.signal_strength : '0;
                    n_out.out_quality        = n_out.write_info ? r_in.link_quality : '0;
                    n_out.post_task          = (w_hit.task_id != '0);
                    n_out.out_task_id        = w_hit.task_id;
                end
            end
            OP_DELETE_RANGE: begin
                if (w_found.range) begin
                    n_out.status = ST_DONE;
                    n_out.slot   = f_slot(w_range_idx);
                    n_valid      = r_valid & ~w_range_hits;
                end
            end
            default: begin
                n_out.status = ST_NOMATCH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_valid     <= n_valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
        if (w_advance && (r_in.op == OP_REGISTER) && w_found.free) begin
            r_entry[w_free_idx] <= '{
                port:           r_in.port,
                limit:          r_in.length_limit,
                ready_address:  r_in.ready_address,
                buffer_address: r_in.buffer_address,
                info_address:   r_in.info_address,
                task_id:        r_in.task_id
            };
        end
    end

    a_register_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && (r_in.op == OP_REGISTER) && w_found.free
        |=> r_valid[$past(w_free_idx)])
        else $error("Registered slot is not valid after register.");

    a_deregister_clears_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && (r_in.op == OP_DEREGISTER) && w_found.port
        |=> !r_valid[$past(w_port_idx)])
        else $error("Deregistered slot is still valid.");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && (r_in.op == OP_REGISTER) && !w_found.free
        |-> (&r_valid))
        else $error("Table reported full while a slot is free.");

endmodule
